[src/ptsc_pkg.sv]
`timescale 1ns / 1ps

package ptsc_pkg;

   // Address, tag placement and tag width of the signed pointer format.
   localparam int ADDR_WIDTH = 32;
   localparam int TAG_SHIFT  = 32;
   localparam int TAG_WIDTH  = 16;

   localparam logic [63:0] ADDRESS_FIELD_MASK = (64'd1 << ADDR_WIDTH) - 64'd1;

   // Key whitening and Murmur3 finaliser constants.
   localparam logic [63:0] FALLBACK_SEED = 64'h4854535F50414321;
   localparam logic [31:0] FMIX_C1       = 32'h85EBCA6B;
   localparam logic [31:0] FMIX_C2       = 32'hC2B2AE35;
   localparam logic [31:0] WHITEN_LO     = 32'h9E3779B9;
   localparam logic [31:0] WHITEN_HI     = 32'h6A09E667;
   localparam int          ROT_R         = 17;
   localparam int          ROT_L         = 15;

   // Register stages between the seed register and the key register.
   localparam int KEY_LATENCY   = 3;
   localparam int KEY_CNT_WIDTH = $clog2(KEY_LATENCY + 1);

   typedef enum logic {
      OP_SIGN = 1'b0,
      OP_AUTH = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      ERR_OK             = 3'd0,
      ERR_KEY_NOT_LOADED = 3'd1,
      ERR_NULL_SIGN      = 3'd2,
      ERR_TAG_MISMATCH   = 3'd3,
      ERR_NULL_RESULT    = 3'd4
   } error_code_type;

   typedef enum logic {
      CSR_KEY_SEED   = 1'b0,
      CSR_KEY_LOADED = 1'b1
   } csr_index_type;

   // Whitened key halves and their cross rotations.
   typedef struct packed {
      logic [31:0] klo;
      logic [31:0] khi;
      logic [31:0] rot_lo;
      logic [31:0] rot_hi;
   } key_type;

   // Per-transaction side information travelling with the hash stages.
   typedef struct packed {
      op_type                 op;
      logic                   key_ok;
      logic                   ptr_zero;
      logic [ADDR_WIDTH-1:0]  addr;
      logic [TAG_WIDTH-1:0]   stored_tag;
   } item_ctl_type;

   // Only the low half of the product is kept, so it is formed at 32 bits.
   function automatic logic [31:0] mul_lo(input logic [31:0] a, input logic [31:0] b);
      return a * b;
   endfunction

   function automatic logic [31:0] xs16(input logic [31:0] h);
      return h ^ (h >> 16);
   endfunction

   function automatic logic [31:0] xs13(input logic [31:0] h);
      return h ^ (h >> 13);
   endfunction

endpackage

[src/ptsc_key_unit.sv]
`timescale 1ns / 1ps

module ptsc_key_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic [63:0]      seed,
   input  logic             seed_write,
   output ptsc_pkg::key_type key,
   output logic             busy
);
   import ptsc_pkg::*;

   logic [31:0] lane_in  [4];
   logic [31:0] k1_in    [4];
   logic [31:0] k1_ff    [4];
   logic [31:0] k2_in    [4];
   logic [31:0] k2_ff    [4];
   logic [63:0] eff_seed;
   logic [31:0] klo;
   logic [31:0] khi;
   key_type     key_in;
   key_type     key_ff;
   logic [KEY_CNT_WIDTH-1:0] cnt_in;
   logic [KEY_CNT_WIDTH-1:0] cnt_ff;

   // Four finaliser lanes run freely on the seed register.
   always_comb begin
      eff_seed   = (seed == 64'd0) ? FALLBACK_SEED : seed;
      lane_in[0] = eff_seed[31:0];
      lane_in[1] = eff_seed[63:32] ^ WHITEN_LO;
      lane_in[2] = eff_seed[63:32];
      lane_in[3] = eff_seed[31:0] ^ WHITEN_HI;
      for (int i = 0; i < 4; i++) begin
         k1_in[i] = mul_lo(xs16(lane_in[i]), FMIX_C1);
         k2_in[i] = mul_lo(xs13(k1_ff[i]), FMIX_C2);
      end
      klo           = xs16(k2_ff[0]) ^ xs16(k2_ff[1]);
      khi           = xs16(k2_ff[2]) ^ xs16(k2_ff[3]);
      key_in.klo    = klo;
      key_in.khi    = khi;
      key_in.rot_lo = (klo >> ROT_R) | (khi << ROT_L);
      key_in.rot_hi = (khi >> ROT_R) | (klo << ROT_L);
   end

   always_ff @(posedge clock) begin
      k1_ff  <= k1_in;
      k2_ff  <= k2_in;
      key_ff <= key_in;
   end

   // The key is settled once a new seed has passed all stages.
   always_comb begin
      if (seed_write) begin
         cnt_in = KEY_CNT_WIDTH'(KEY_LATENCY);
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - KEY_CNT_WIDTH'(1);
      end else begin
         cnt_in = cnt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= KEY_CNT_WIDTH'(KEY_LATENCY);
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   assign key  = key_ff;
   assign busy = (cnt_ff != '0);

endmodule

[src/ptsc_tag_pipe.sv]
`timescale 1ns / 1ps

module ptsc_tag_pipe (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic               in_op,
   input  logic [63:0]        in_pointer,
   input  logic               key_loaded,
   input  ptsc_pkg::key_type  key,
   output logic               out_valid,
   output logic [63:0]        out_result,
   output logic [2:0]         out_error
);
   import ptsc_pkg::*;

   logic [63:0]    masked;
   logic [31:0]    a32;

   logic           s1_valid_in, s1_valid_ff;
   logic           s2_valid_ff, s3_valid_ff, out_valid_ff;
   item_ctl_type   s1_ctl_in, s1_ctl_ff, s2_ctl_ff, s3_ctl_ff;
   logic [31:0]    s1_mlo_in, s1_mhi_in, s1_mlo_ff, s1_mhi_ff;
   logic [31:0]    s2_hlo_in, s2_hhi_in, s2_hlo_ff, s2_hhi_ff;
   logic [31:0]    s3_hlo_in, s3_hhi_in, s3_hlo_ff, s3_hhi_ff;
   logic [TAG_WIDTH-1:0] tag;
   logic [63:0]    result_in, result_ff;
   error_code_type error_in, error_ff;

   // Stage 1: mix the address with the key halves.
   always_comb begin
      masked               = in_pointer & ADDRESS_FIELD_MASK;
      a32                  = masked[31:0];
      s1_valid_in          = in_valid;
      s1_ctl_in.op         = op_type'(in_op);
      s1_ctl_in.key_ok     = key_loaded;
      s1_ctl_in.ptr_zero   = (in_pointer == 64'd0);
      s1_ctl_in.addr       = masked[ADDR_WIDTH-1:0];
      s1_ctl_in.stored_tag = TAG_WIDTH'(in_pointer >> TAG_SHIFT);
      s1_mlo_in            = (a32 ^ key.klo) + key.rot_lo;
      s1_mhi_in            = (a32 ^ key.khi) + key.rot_hi;
      s2_hlo_in            = mul_lo(xs16(s1_mlo_ff), FMIX_C1);
      s2_hhi_in            = mul_lo(xs16(s1_mhi_ff), FMIX_C1);
      s3_hlo_in            = mul_lo(xs13(s2_hlo_ff), FMIX_C2);
      s3_hhi_in            = mul_lo(xs13(s2_hhi_ff), FMIX_C2);
   end

   // Final stage: finish the hash, check and build the result.
   always_comb begin
      tag       = TAG_WIDTH'(xs16(s3_hlo_ff) ^ xs16(s3_hhi_ff));
      result_in = 64'd0;
      error_in  = ERR_OK;
      if (!s3_ctl_ff.key_ok) begin
         error_in = ERR_KEY_NOT_LOADED;
      end else if (s3_ctl_ff.op == OP_SIGN) begin
         if (s3_ctl_ff.ptr_zero) begin
            error_in = ERR_NULL_SIGN;
         end else begin
            result_in = (64'(tag) << TAG_SHIFT) | 64'(s3_ctl_ff.addr);
         end
      end else begin
         if (s3_ctl_ff.stored_tag != tag) begin
            error_in = ERR_TAG_MISMATCH;
         end else if (s3_ctl_ff.addr == '0) begin
            error_in = ERR_NULL_RESULT;
         end else begin
            result_in = 64'(s3_ctl_ff.addr);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         out_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_ctl_ff <= s1_ctl_in;
      s1_mlo_ff <= s1_mlo_in;
      s1_mhi_ff <= s1_mhi_in;
      s2_ctl_ff <= s1_ctl_ff;
      s2_hlo_ff <= s2_hlo_in;
      s2_hhi_ff <= s2_hhi_in;
      s3_ctl_ff <= s2_ctl_ff;
      s3_hlo_ff <= s3_hlo_in;
      s3_hhi_ff <= s3_hhi_in;
      result_ff <= result_in;
      error_ff  <= error_in;
   end

   assign out_valid  = out_valid_ff;
   assign out_result = result_ff;
   assign out_error  = error_ff;

endmodule

[src/pointer_tag_sign_and_check_unit.sv]
`timescale 1ns / 1ps

// Keyed pointer tag unit: signs plain pointers and checks signed ones.
//
// Input transactions are issued on start with req_op and req_pointer_value;
// one is taken at each rising edge at which start is high and busy is low.
// A new transaction may be issued in every cycle while busy is low, so the
// sustained rate is one transaction per clock.
// Every transaction yields exactly one response on rsp_result_value and
// rsp_error_code, shown for one cycle with rsp_strobe high. The response
// passes through the pipeline stages in order: one stage mixes the address
// with the key, two stages hold the finaliser multiplies and the last stage
// compares the tag and registers the response. The receiver cannot stall, so
// responses leave in issue order without any back-pressure.
// The key seed and the key-loaded flag are written through the csr_ port.
// After a seed write, and after reset, the key is rederived by its own
// three-stage finaliser pipeline; busy is high until the key is settled and
// no transaction is taken meanwhile. Reset empties the pipeline, clears the
// seed to zero (which selects the fixed fallback seed) and clears the
// key-loaded flag, so every transaction is refused until it is set again.

module pointer_tag_sign_and_check_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_op,
   input  logic [63:0] req_pointer_value,
   output logic        rsp_strobe,
   output logic [63:0] rsp_result_value,
   output logic [2:0]  rsp_error_code,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [63:0] csr_write_data
);
   import ptsc_pkg::*;

   logic        seed_in, seed_write;
   logic [63:0] key_seed_in, key_seed_ff;
   logic        key_loaded_in, key_loaded_ff;
   logic        accept;
   key_type     key;

   // Configuration writes; the seed write also restarts key derivation.
   always_comb begin
      key_seed_in   = key_seed_ff;
      key_loaded_in = key_loaded_ff;
      seed_write    = 1'b0;
      if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_KEY_SEED: begin
               key_seed_in = csr_write_data;
               seed_write  = 1'b1;
            end
            CSR_KEY_LOADED: begin
               key_loaded_in = csr_write_data[0];
            end
            default: begin
               seed_write = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_seed_ff   <= 64'd0;
         key_loaded_ff <= 1'b0;
      end else begin
         key_seed_ff   <= key_seed_in;
         key_loaded_ff <= key_loaded_in;
      end
   end

   // The counter in the key unit loads on the edge that writes the seed.
   assign seed_in = seed_write;

   ptsc_key_unit u_key (
      .clock      (clock),
      .reset      (reset),
      .seed       (key_seed_ff),
      .seed_write (seed_in),
      .key        (key),
      .busy       (busy)
   );

   assign accept = start && !busy;

   ptsc_tag_pipe u_pipe (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (accept),
      .in_op      (req_op),
      .in_pointer (req_pointer_value),
      .key_loaded (key_loaded_ff),
      .key        (key),
      .out_valid  (rsp_strobe),
      .out_result (rsp_result_value),
      .out_error  (rsp_error_code)
   );

   // Every response stems from an earlier accepted transaction.
   a_rsp_has_origin : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, 4))
      else $error("response without an accepted transaction");

   // Every accepted transaction produces a response.
   a_accept_answered : assert property (@(posedge clock) disable iff (reset)
      accept |-> ##4 rsp_strobe)
      else $error("accepted transaction lost");

   // A refused transaction never carries a pointer value.
   a_error_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_error_code != ERR_OK) |-> (rsp_result_value == 64'd0))
      else $error("error response with nonzero result");

   // A seed write holds off transactions while the key is rederived.
   a_seed_busy : assert property (@(posedge clock) disable iff (reset)
      (csr_write_enable && csr_index == CSR_KEY_SEED) |=> busy)
      else $error("transaction window open during key derivation");

endmodule
